@@ rtl/core/fire_effect_grid_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Fire effect grid unit: assertion macros
// Concurrent check macros shared by the RTL files; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FIRE_EFFECT_GRID_UNIT_DEFINES_SVH
`define FIRE_EFFECT_GRID_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define FEGU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FEGU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FEGU_ASSERT_IMP(label, ante, cons, msg)
`define FEGU_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/fegu_pkg.sv @@
// ----------------------------------------------------------------------------
// Fire effect grid unit: package
// Grid geometry, field widths, constants, shared types and the palette entry.
// ----------------------------------------------------------------------------
package fegu_pkg;

    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 64;
    localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int ADDR_W     = $clog2(GRID_CELLS);

    localparam int HEAT_W     = 8;
    localparam int PAL_DEPTH  = 2 ** HEAT_W;
    localparam int FIELD_W    = 6;
    localparam int WEIGHT_W   = 7;
    localparam int END_W      = 10;
    localparam int SPREAD_W   = 11;
    localparam int NOISE_W    = 16;
    localparam int NUM_W      = 18;
    localparam int THR_W      = NUM_W + NOISE_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [HEAT_W-1:0]   HEAT_SEED    = 8'd254;
    localparam logic [NOISE_W-1:0]  NOISE_RESET  = 16'hACE1;
    localparam logic [NOISE_W-1:0]  NOISE_SPAN   = 16'd65502;
    localparam logic [6:0]          PCT_SCALE    = 7'd100;
    localparam logic [END_W-1:0]    END_RESET    = 10'd256;
    localparam logic [SPREAD_W-1:0] SPREAD_RESET = 11'd1;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [HEAT_W-1:0] intensity;
    } fegu_res_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } fegu_rgb_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(int'(r) * GRID_COLS + int'(c));
    endfunction

    // evaluated at elaboration only
    function automatic fegu_rgb_t pal_entry(input int i);
        int        k;
        fegu_rgb_t c;
        c = '0;
        if (i < 10)
        begin
            c.blue = 8'((((i * 100) / 10) * 255) / 100);
        end
        else if (i < 50)
        begin
            k      = ((((i - 10) * 100) / 40) * 255) / 100;
            c.red  = 8'(k);
            c.blue = 8'(255 - k);
        end
        else if (i < 150)
        begin
            c.red   = 8'd255;
            c.green = 8'(((((i - 50) * 100) / 100) * 255) / 100);
        end
        else
        begin
            c.red   = 8'd255;
            c.green = 8'd255;
            c.blue  = 8'(((((i - 150) * 100) / 105) * 255) / 100);
        end
        return c;
    endfunction

endpackage

@@ rtl/core/fegu_div.sv @@
// ----------------------------------------------------------------------------
// Fire effect grid unit: divider
// Restoring divider, one quotient bit per cycle, done pulses after NUM_W steps.
// ----------------------------------------------------------------------------
`include "fire_effect_grid_unit_defines.svh"

module fegu_div
    import fegu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [END_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [END_W-1:0] rem_reg;
    logic [END_W-1:0] den_reg;
    logic [NUM_W-1:0] q_reg;

    logic [END_W:0]   trial;
    logic             q_bit;
    logic [END_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, q_reg[NUM_W-1]};
        q_bit = (trial >= {1'b0, den_reg});
        if (q_bit)
        begin
            rem_next = END_W'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = trial[END_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

    `FEGU_ASSERT_IMP(a_start_idle, start, !busy_reg, "divider started while busy")
    `FEGU_ASSERT_IMP(a_done_idle, done_reg, !busy_reg, "divider done while still busy")

endmodule

@@ rtl/core/fegu_palette.sv @@
// ----------------------------------------------------------------------------
// Fire effect grid unit: palette
// Constant fire palette lookup, intensity to red, green and blue.
// ----------------------------------------------------------------------------
module fegu_palette
    import fegu_pkg::*;
(
    input  logic [HEAT_W-1:0] intensity,
    output fegu_rgb_t         rgb
);

    fegu_rgb_t pal_rom [PAL_DEPTH];

    for (genvar g = 0; g < PAL_DEPTH; g++)
    begin : g_rom
        localparam fegu_rgb_t ENTRY = pal_entry(g);
        assign pal_rom[g] = ENTRY;
    end

    assign rgb = pal_rom[intensity];

endmodule

@@ rtl/core/fegu_engine.sv @@
// ----------------------------------------------------------------------------
// Fire effect grid unit: grid engine
// Heat grid memory with its sequencer: clear pass, cell reads, seeding of the
// bottom row from the noise source and the in-place upward heat pass.
// ----------------------------------------------------------------------------
`include "fire_effect_grid_unit_defines.svh"

module fegu_engine
    import fegu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_func,
    input  logic [WEIGHT_W-1:0] in_weight,
    input  logic [FIELD_W-1:0]  in_col,
    input  logic [FIELD_W-1:0]  in_row,
    input  logic [END_W-1:0]    end_eff,
    output fegu_res_t           res,
    input  logic                res_ready
);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_READ   = 10'b00_0000_0100,
        S_DIV    = 10'b00_0000_1000,
        S_THRESH = 10'b00_0001_0000,
        S_SEED   = 10'b00_0010_0000,
        S_PRIME  = 10'b00_0100_0000,
        S_ROW    = 10'b00_1000_0000,
        S_DRAIN  = 10'b01_0000_0000,
        S_HOLD   = 10'b10_0000_0000
    } state_t;

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(GRID_COLS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(GRID_ROWS - 1);
    localparam logic [ROW_W-1:0]  FIRST_UPD = ROW_W'(GRID_ROWS - 2);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(GRID_CELLS - 1);

    logic [HEAT_W-1:0] heat_mem [GRID_CELLS];

    state_t              state_reg;
    state_t              state_next;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic                p_valid_reg;
    logic                prime_reg;
    logic [ROW_W-1:0]    p_row_reg;
    logic [COL_W-1:0]    p_col_reg;
    logic [NOISE_W-1:0]  noise_reg;
    logic [SPREAD_W-1:0] spread_reg;
    logic                in_range_reg;

    logic [WEIGHT_W-1:0] weight_reg;
    logic [THR_W-1:0]    thresh_reg;
    logic [HEAT_W-1:0]   left_reg;
    logic [HEAT_W-1:0]   centre_reg;
    logic [HEAT_W-1:0]   res_int_reg;
    logic [HEAT_W-1:0]   rd_a_reg;
    logic [HEAT_W-1:0]   rd_b_reg;

    logic                accept;
    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    div_num;
    logic [NUM_W-1:0]    div_quot;
    logic                in_range;
    logic [NOISE_W-1:0]  noise_step;
    logic [THR_W-1:0]    noise_scaled;
    logic                seed_hot;
    logic [HEAT_W-1:0]   right_val;
    logic [HEAT_W+1:0]   heat_sum;
    logic [HEAT_W-1:0]   heat_avg;
    logic [HEAT_W-1:0]   proc_val;
    logic [SPREAD_W:0]   spread_sum;
    logic [ADDR_W-1:0]   rd_a_addr;
    logic [ADDR_W-1:0]   rd_b_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [HEAT_W-1:0]   wr_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign div_start = accept && (in_func == FUNC_UPDATE);
    assign div_num   = NUM_W'(spread_reg) * NUM_W'(PCT_SCALE);
    assign in_range  = (int'(in_row) < GRID_ROWS) && (int'(in_col) < GRID_COLS);

    fegu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (end_eff),
        .done  (div_done),
        .quot  (div_quot)
    );

    // noise source and seed decision: rnd < percent  <=>  noise*100 < percent*span
    always_comb
    begin
        noise_step   = {noise_reg[0] ^ noise_reg[2] ^ noise_reg[3] ^ noise_reg[5],
                        noise_reg[NOISE_W-1:1]};
        noise_scaled = THR_W'(noise_step) * THR_W'(PCT_SCALE);
        seed_hot     = (noise_scaled < thresh_reg);
    end

    // heat pass datapath
    always_comb
    begin
        right_val = (p_col_reg == LAST_COL) ? '0 : rd_a_reg;
        heat_sum  = (HEAT_W+2)'(left_reg) + (HEAT_W+2)'(centre_reg)
                  + (HEAT_W+2)'(rd_b_reg) + (HEAT_W+2)'(right_val);
        heat_avg  = heat_sum[HEAT_W+1:2];
        proc_val  = (heat_avg > HEAT_W'(1)) ? heat_avg - 1'b1 : heat_avg;
        spread_sum = (SPREAD_W+1)'(spread_reg) + (SPREAD_W+1)'(weight_reg);
    end

    always_comb
    begin
        rd_a_addr = '0;
        rd_b_addr = cell_addr(ROW_W'(row_reg + 1'b1), col_reg);
        wr_en     = 1'b0;
        wr_addr   = cell_addr(p_row_reg, p_col_reg);
        wr_data   = proc_val;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            S_IDLE:
            begin
                rd_a_addr = cell_addr(ROW_W'(in_row), COL_W'(in_col));
            end
            S_SEED:
            begin
                wr_en   = 1'b1;
                wr_addr = cell_addr(LAST_ROW, col_reg);
                wr_data = seed_hot ? HEAT_SEED : '0;
            end
            S_PRIME:
            begin
                rd_a_addr = cell_addr(row_reg, '0);
            end
            S_ROW:
            begin
                rd_a_addr = cell_addr(row_reg, COL_W'(col_reg + 1'b1));
            end
            default:
            begin
            end
        endcase
        if (p_valid_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_addr_reg == LAST_ADDR) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_func == FUNC_READ) ? S_READ : S_DIV;
                end
            end
            S_READ:   state_next = S_HOLD;
            S_DIV:    if (div_done) state_next = S_THRESH;
            S_THRESH: state_next = S_SEED;
            S_SEED:   if (col_reg == LAST_COL) state_next = S_PRIME;
            S_PRIME:  state_next = S_ROW;
            S_ROW:
            begin
                if (col_reg == LAST_COL)
                begin
                    state_next = (row_reg == ROW_W'(1)) ? S_DRAIN : S_PRIME;
                end
            end
            S_DRAIN:  state_next = S_HOLD;
            S_HOLD:   if (res_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            p_valid_reg  <= 1'b0;
            prime_reg    <= 1'b0;
            p_row_reg    <= '0;
            p_col_reg    <= '0;
            noise_reg    <= NOISE_RESET;
            spread_reg   <= SPREAD_RESET;
            in_range_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= (state_reg == S_ROW);
            prime_reg   <= (state_reg == S_PRIME);
            p_row_reg   <= row_reg;
            p_col_reg   <= col_reg;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (accept)
            begin
                in_range_reg <= in_range;
            end
            if (state_reg == S_THRESH)
            begin
                col_reg <= '0;
            end
            if (state_reg == S_SEED)
            begin
                noise_reg <= noise_step;
                col_reg   <= col_reg + 1'b1;
                if (col_reg == LAST_COL)
                begin
                    col_reg <= '0;
                    row_reg <= FIRST_UPD;
                end
            end
            if (state_reg == S_ROW)
            begin
                col_reg <= col_reg + 1'b1;
                if (col_reg == LAST_COL)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg - 1'b1;
                end
            end
            if (state_reg == S_DRAIN)
            begin
                if (spread_sum >= (SPREAD_W+1)'(end_eff))
                begin
                    spread_reg <= SPREAD_RESET;
                end
                else
                begin
                    spread_reg <= spread_sum[SPREAD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            weight_reg <= in_weight;
        end
        if (state_reg == S_THRESH)
        begin
            thresh_reg <= THR_W'(div_quot) * THR_W'(NOISE_SPAN);
        end
        if (prime_reg)
        begin
            centre_reg <= rd_a_reg;
            left_reg   <= '0;
        end
        else if (p_valid_reg)
        begin
            centre_reg <= rd_a_reg;
            left_reg   <= proc_val;
        end
        if (state_reg == S_READ)
        begin
            res_int_reg <= in_range_reg ? rd_a_reg : '0;
        end
        else if (state_reg == S_DRAIN)
        begin
            res_int_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heat_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heat_mem[rd_a_addr];
        rd_b_reg <= heat_mem[rd_b_addr];
    end

    assign res.valid     = (state_reg == S_HOLD);
    assign res.intensity = res_int_reg;

    `FEGU_ASSERT_IMP(a_no_write_idle, (state_reg == S_IDLE) || (state_reg == S_HOLD), !wr_en, "grid written while idle")
    `FEGU_ASSERT_IMP(a_heat_bound, wr_en, wr_data <= HEAT_SEED, "heat above seed value")
    `FEGU_ASSERT_NXT(a_noise_hold, state_reg != S_SEED, $stable(noise_reg), "noise moved outside seeding")
    `FEGU_ASSERT_IMP(a_div_done_state, div_done, state_reg == S_DIV, "divider result unexpected")

endmodule

@@ rtl/core/fire_effect_grid_unit.sv @@
// ----------------------------------------------------------------------------
// Fire effect grid unit: top level
// Stream ports, displacement end register and result output register.
// ----------------------------------------------------------------------------
// One item at a time. A read beat's result passes through the S_READ and S_HOLD
// states of the engine and the result output register before it is offered
// on m_axis. An update beat walks the grid once through the single write port
// of the heat memory: the percent divide, seeding of the bottom row, then a
// priming read and a pass along each of rows GRID_ROWS-2 down to 1; its
// result beat is all zero.
// After reset all GRID_ROWS*GRID_COLS (4096) cells of the heat memory are
// cleared one cell a cycle, with s_axis_tready low; cfg writes are taken
// at any time. The result register lets the next beat in while a result waits.
// ----------------------------------------------------------------------------
module fire_effect_grid_unit
    import fegu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // weight[6:0], cell_col[12:7], cell_row[18:13]
    input  logic                  s_axis_tuser,   // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // intensity, red, green, blue
    input  logic                  cfg_wr_en,
    input  logic [END_W-1:0]      cfg_wr_data
);

    logic [END_W-1:0]      end_reg;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [END_W-1:0]      end_eff;
    fegu_res_t             res;
    logic                  res_ready;
    fegu_rgb_t             rgb;

    assign end_eff   = (end_reg == '0) ? END_W'(1) : end_reg;
    assign res_ready = !m_valid_reg || m_axis_tready;

    fegu_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_weight (s_axis_tdata[WEIGHT_W-1:0]),
        .in_col    (s_axis_tdata[WEIGHT_W+FIELD_W-1:WEIGHT_W]),
        .in_row    (s_axis_tdata[WEIGHT_W+2*FIELD_W-1:WEIGHT_W+FIELD_W]),
        .end_eff   (end_eff),
        .res       (res),
        .res_ready (res_ready)
    );

    fegu_palette u_palette (
        .intensity (res.intensity),
        .rgb       (rgb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg     <= END_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                end_reg <= cfg_wr_data;
            end
            if (res.valid && res_ready)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            m_data_reg <= {rgb.blue, rgb.green, rgb.red, res.intensity};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
